>>> design/http_header_block_parser_macros.svh
// assertion macros for the http header block parser
`ifndef HTTP_HEADER_BLOCK_PARSER_MACROS_SVH
`define HTTP_HEADER_BLOCK_PARSER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every clk edge outside reset
`define HHBP_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hhbp assertion failed");

// next-cycle implication
`define HHBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hhbp assertion failed");

`else

`define HHBP_ASSERT_IMPLIES(label, ante, cons)
`define HHBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/hhbp_pkg.sv
// types and constants shared by the http header block parser
package hhbp_pkg;

  localparam int COUNT_WIDTH_DEF = 10;

  localparam int BYTE_W  = 8;
  localparam int CLASS_W = 4;
  localparam int CODE_W  = 3;
  localparam int LEN_W   = 10;
  localparam int STATE_W = 4;

  localparam logic [LEN_W-1:0] LEN_MAX         = '1;
  localparam logic [LEN_W-1:0] MAX_VALUE_RESET = LEN_W'(256);

  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

  // parser states
  localparam logic [STATE_W-1:0] ST_START       = 4'd0;
  localparam logic [STATE_W-1:0] ST_KEY         = 4'd1;
  localparam logic [STATE_W-1:0] ST_AFTER_COLON = 4'd2;
  localparam logic [STATE_W-1:0] ST_AFTER_SPACE = 4'd3;
  localparam logic [STATE_W-1:0] ST_VALUE       = 4'd4;
  localparam logic [STATE_W-1:0] ST_LINE_CR     = 4'd5;
  localparam logic [STATE_W-1:0] ST_LINE_LF     = 4'd6;
  localparam logic [STATE_W-1:0] ST_END_CR      = 4'd7;
  localparam logic [STATE_W-1:0] ST_DONE        = 4'd8;
  localparam logic [STATE_W-1:0] ST_FAILED      = 4'd9;

  // byte classes
  localparam logic [CLASS_W-1:0] CLS_SKIP    = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_KEY     = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_COLON   = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_SPACE   = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_VALUE   = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_LINE_CR = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_LINE_LF = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_END_CR  = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_END_LF  = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_IGNORED = 4'd9;

  // error codes
  localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [CODE_W-1:0] ERR_NO_SPACE    = 3'd1;
  localparam logic [CODE_W-1:0] ERR_CR_IN_KEY   = 3'd2;
  localparam logic [CODE_W-1:0] ERR_VALUE_LONG  = 3'd3;
  localparam logic [CODE_W-1:0] ERR_LINE_NO_LF  = 3'd4;
  localparam logic [CODE_W-1:0] ERR_END_NO_LF   = 3'd5;

  typedef struct packed {
    logic [CLASS_W-1:0] byte_class;
    logic               header_done;
    logic               error_flag;
    logic [CODE_W-1:0]  error_code;
    logic [LEN_W-1:0]   field_length;
  } res_t;

endpackage

>>> design/hhbp_if.sv
// valid/ready channels for header bytes and classified results
interface hhbp_in_if;
  import hhbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              new_request;

  modport source (output valid, output data_byte, output new_request, input ready);
  modport sink (input valid, input data_byte, input new_request, output ready);
endinterface

interface hhbp_out_if;
  import hhbp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] byte_class;
  logic               header_done;
  logic               error_flag;
  logic [CODE_W-1:0]  error_code;
  logic [LEN_W-1:0]   field_length;

  modport source (output valid, output byte_class, output header_done, output error_flag,
                  output error_code, output field_length, input ready);
  modport sink (input valid, input byte_class, input header_done, input error_flag,
                input error_code, input field_length, output ready);
endinterface

>>> design/hhbp_core.sv
// parser state machine with key and value counters
module hhbp_core
  import hhbp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               new_request,
  input  logic [LEN_W-1:0]   max_value_bytes,
  output res_t               res
);

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [STATE_W-1:0]     state, state_next;
  logic [COUNT_WIDTH-1:0] key_count, key_count_next;
  logic [COUNT_WIDTH-1:0] value_count, value_count_next;

  logic [STATE_W-1:0]     cur_state;
  logic [COUNT_WIDTH-1:0] cur_key, cur_value;
  logic [CMP_W-1:0]       key_w, value_w;
  logic [LEN_W-1:0]       key_len, value_len;

  // a new request restarts the parser before this byte
  assign cur_state = new_request ? ST_START : state;
  assign cur_key   = new_request ? '0 : key_count;
  assign cur_value = new_request ? '0 : value_count;

  assign key_w     = CMP_W'(cur_key);
  assign value_w   = CMP_W'(cur_value);
  assign key_len   = (key_w > CMP_W'(LEN_MAX)) ? LEN_MAX : key_w[LEN_W-1:0];
  assign value_len = (value_w > CMP_W'(LEN_MAX)) ? LEN_MAX : value_w[LEN_W-1:0];

  always_comb begin
    res              = '0;
    res.byte_class   = CLS_IGNORED;
    res.error_code   = ERR_NONE;
    state_next       = cur_state;
    key_count_next   = cur_key;
    value_count_next = cur_value;
    case (cur_state)
      ST_START: begin
        if (data_byte == BYTE_CR || data_byte == BYTE_LF) begin
          res.byte_class = CLS_SKIP;
        end else begin
          res.byte_class = CLS_KEY;
          key_count_next = CNT_ONE;
          state_next     = ST_KEY;
        end
      end
      ST_KEY: begin
        if (data_byte == BYTE_COLON) begin
          res.byte_class   = CLS_COLON;
          res.field_length = key_len;
          state_next       = ST_AFTER_COLON;
        end else if (data_byte == BYTE_CR) begin
          res.error_flag = 1'b1;
          res.error_code = ERR_CR_IN_KEY;
        end else begin
          res.byte_class = CLS_KEY;
          key_count_next = (cur_key == CNT_MAX) ? CNT_MAX : cur_key + CNT_ONE;
        end
      end
      ST_AFTER_COLON: begin
        if (data_byte == BYTE_SPACE) begin
          res.byte_class = CLS_SPACE;
          state_next     = ST_AFTER_SPACE;
        end else begin
          res.error_flag = 1'b1;
          res.error_code = ERR_NO_SPACE;
        end
      end
      ST_AFTER_SPACE: begin
        // first value byte is taken whatever it is
        res.byte_class   = CLS_VALUE;
        value_count_next = CNT_ONE;
        state_next       = ST_VALUE;
      end
      ST_VALUE: begin
        if (data_byte == BYTE_CR) begin
          res.byte_class   = CLS_LINE_CR;
          res.field_length = value_len;
          state_next       = ST_LINE_CR;
        end else if (value_w >= CMP_W'(max_value_bytes)) begin
          res.error_flag = 1'b1;
          res.error_code = ERR_VALUE_LONG;
        end else begin
          res.byte_class   = CLS_VALUE;
          value_count_next = (cur_value == CNT_MAX) ? CNT_MAX : cur_value + CNT_ONE;
        end
      end
      ST_LINE_CR: begin
        if (data_byte == BYTE_LF) begin
          res.byte_class = CLS_LINE_LF;
          state_next     = ST_LINE_LF;
        end else begin
          res.error_flag = 1'b1;
          res.error_code = ERR_LINE_NO_LF;
        end
      end
      ST_LINE_LF: begin
        if (data_byte == BYTE_CR) begin
          res.byte_class = CLS_END_CR;
          state_next     = ST_END_CR;
        end else begin
          res.byte_class = CLS_KEY;
          key_count_next = CNT_ONE;
          state_next     = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (data_byte == BYTE_LF) begin
          res.byte_class  = CLS_END_LF;
          res.header_done = 1'b1;
          state_next      = ST_DONE;
        end else begin
          res.error_flag = 1'b1;
          res.error_code = ERR_END_NO_LF;
        end
      end
      default: begin
        state_next = (cur_state == ST_DONE) ? ST_DONE : ST_FAILED;
      end
    endcase
    if (res.error_flag) begin
      state_next = ST_FAILED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_START;
      key_count   <= '0;
      value_count <= '0;
    end else if (advance) begin
      state       <= state_next;
      key_count   <= key_count_next;
      value_count <= value_count_next;
    end
  end

endmodule

>>> design/http_header_block_parser.sv
// the result of each transferred byte is held in the result register
// throughput: one byte per cycle unless results stall; the state machine and counters update in a single pass
// the result register lets a new byte in while the previous result is being taken
// reset (synchronous, active high) puts the parser in its start state, clears both counts
// and the result valid, and sets max_value_bytes to 256
`include "http_header_block_parser_macros.svh"

module http_header_block_parser
  import hhbp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  hhbp_in_if.sink          bytes,
  hhbp_out_if.source       results,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] max_value_bytes;
  logic             accept;
  logic             out_valid;
  res_t             res_next, res;

  assign bytes.ready = !out_valid || results.ready;
  assign accept      = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_bytes <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      max_value_bytes <= cfg_data;
    end
  end

  hhbp_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .data_byte      (bytes.data_byte),
    .new_request    (bytes.new_request),
    .max_value_bytes(max_value_bytes),
    .res            (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.byte_class   = res.byte_class;
  assign results.header_done  = res.header_done;
  assign results.error_flag   = res.error_flag;
  assign results.error_code   = res.error_code;
  assign results.field_length = res.field_length;

  `HHBP_ASSERT_IMPLIES(a_err_ignored, out_valid && res.error_flag,
    res.byte_class == CLS_IGNORED && res.field_length == '0)
  `HHBP_ASSERT_IMPLIES(a_code_flag, out_valid, res.error_flag == (res.error_code != ERR_NONE))
  `HHBP_ASSERT_IMPLIES(a_done_end_lf, out_valid && res.header_done,
    res.byte_class == CLS_END_LF && !res.error_flag)
  `HHBP_ASSERT_IMPLIES(a_stall_blocks, out_valid && !results.ready, !bytes.ready)
  `HHBP_ASSERT_NEXT(a_accept_valid, accept, out_valid)

endmodule
